// ===== design/sbl_pkg.sv =====
// Shared constants, types and limits for the Sobel edge magnitude unit.
package sbl_pkg;

   // Image geometry and pixel format
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int PIXEL_BITS = 8;

   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
   localparam int WIDTH_BITS  = COL_BITS + 1;
   localparam int HEIGHT_BITS = ROW_BITS + 1;

   // Gradient and magnitude widths
   localparam int SUM_BITS   = PIXEL_BITS + 2;
   localparam int GRAD_BITS  = PIXEL_BITS + 3;
   localparam int MAG_BITS   = GRAD_BITS;
   localparam int SUMSQ_BITS = 2 * MAG_BITS;

   // Register file
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;
   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);
   localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN    = WIDTH_BITS'(3);
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN   = HEIGHT_BITS'(3);
   localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX    = WIDTH_BITS'(MAX_WIDTH);
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX   = HEIGHT_BITS'(MAX_HEIGHT);

   // Gradient queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // Last column and last row of the effective frame
   typedef struct packed {
      logic [COL_BITS-1:0] col_last;
      logic [ROW_BITS-1:0] row_last;
   } sbl_limits_type;

   // One gradient job handed from front to back
   typedef struct packed {
      logic signed [GRAD_BITS-1:0] gx;
      logic signed [GRAD_BITS-1:0] gy;
      logic [COL_BITS-1:0]         col;
      logic [ROW_BITS-1:0]         row;
      logic                        frame_end;
   } sbl_job_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic room;
      logic not_empty;
   } sbl_qstat_type;

endpackage

// ===== design/sbl_front.sv =====
// Pixel intake: position counters, line stores, window taps and gradients.
module sbl_front import sbl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  sbl_limits_type        limits,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIXEL_BITS-1:0] req_pixel,
   input  logic                  req_frame_start,
   input  sbl_qstat_type         qstat,
   output logic                  push,
   output sbl_job_type           push_job
);

   logic [PIXEL_BITS-1:0] upper_line_mem  [0:MAX_WIDTH-1];
   logic [PIXEL_BITS-1:0] middle_line_mem [0:MAX_WIDTH-1];

   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0] c0;
   logic [ROW_BITS-1:0] r0;
   logic                accept;
   logic                advance;

   logic                  s1_valid_ff, s1_valid_in;
   logic [COL_BITS-1:0]   s1_col_ff;
   logic [ROW_BITS-1:0]   s1_row_ff;
   logic [PIXEL_BITS-1:0] s1_pix_ff;
   logic                  s1_interior_ff;
   logic                  s1_frame_end_ff;
   logic [PIXEL_BITS-1:0] up_rd_ff, mid_rd_ff;
   logic                  byp_ff;
   logic [PIXEL_BITS-1:0] fwd_up_ff, fwd_mid_ff;
   logic [PIXEL_BITS-1:0] up_eff, mid_eff;

   logic [PIXEL_BITS-1:0] tap_ff [0:5];

   logic [SUM_BITS-1:0] gx_left, gx_right, gy_top, gy_bottom;

   // Position of the incoming pixel
   assign c0 = req_frame_start ? '0 : col_ff;
   assign r0 = req_frame_start ? '0 : row_ff;

   // Stage one retires when the queue can take its job or it has none
   assign advance   = s1_valid_ff && (qstat.room || !s1_interior_ff);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // Advance column and row counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (c0 >= limits.col_last) begin
            col_in = '0;
            row_in = (r0 >= limits.row_last) ? '0 : r0 + 1'b1;
         end else begin
            col_in = c0 + 1'b1;
            row_in = r0;
         end
      end
   end

   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Capture the accepted pixel and read both line stores
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff       <= c0;
         s1_row_ff       <= r0;
         s1_pix_ff       <= req_pixel;
         s1_interior_ff  <= (c0 >= COL_BITS'(2)) && (r0 >= ROW_BITS'(2));
         s1_frame_end_ff <= (c0 == limits.col_last) && (r0 == limits.row_last);
         up_rd_ff        <= upper_line_mem[c0];
         mid_rd_ff       <= middle_line_mem[c0];
         byp_ff          <= advance && (s1_col_ff == c0);
         fwd_up_ff       <= mid_eff;
         fwd_mid_ff      <= s1_pix_ff;
      end
   end

   // Forward a write that lands on the address read in the same cycle
   assign up_eff  = byp_ff ? fwd_up_ff  : up_rd_ff;
   assign mid_eff = byp_ff ? fwd_mid_ff : mid_rd_ff;

   // Shift the column down through the line stores
   always_ff @(posedge clock) begin
      if (advance) begin
         upper_line_mem[s1_col_ff]  <= mid_eff;
         middle_line_mem[s1_col_ff] <= s1_pix_ff;
      end
   end

   // Shift the window one column left
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            tap_ff[i] <= '0;
         end
      end else if (advance) begin
         tap_ff[0] <= tap_ff[3];
         tap_ff[1] <= tap_ff[4];
         tap_ff[2] <= tap_ff[5];
         tap_ff[3] <= up_eff;
         tap_ff[4] <= mid_eff;
         tap_ff[5] <= s1_pix_ff;
      end
   end

   // Kernel sums: left minus right column, top minus bottom row
   assign gx_left   = SUM_BITS'(tap_ff[0]) + {1'b0, tap_ff[1], 1'b0} + SUM_BITS'(tap_ff[2]);
   assign gx_right  = SUM_BITS'(up_eff) + {1'b0, mid_eff, 1'b0} + SUM_BITS'(s1_pix_ff);
   assign gy_top    = SUM_BITS'(tap_ff[0]) + {1'b0, tap_ff[3], 1'b0} + SUM_BITS'(up_eff);
   assign gy_bottom = SUM_BITS'(tap_ff[2]) + {1'b0, tap_ff[5], 1'b0} + SUM_BITS'(s1_pix_ff);

   assign push               = advance && s1_interior_ff;
   assign push_job.gx        = $signed({1'b0, gx_left}) - $signed({1'b0, gx_right});
   assign push_job.gy        = $signed({1'b0, gy_top}) - $signed({1'b0, gy_bottom});
   assign push_job.col       = s1_col_ff - 1'b1;
   assign push_job.row       = s1_row_ff - 1'b1;
   assign push_job.frame_end = s1_frame_end_ff;

endmodule

// ===== design/sbl_queue.sv =====
// Short job queue between the gradient front and the magnitude back.
module sbl_queue import sbl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  sbl_job_type   push_job,
   input  logic          pop,
   output sbl_job_type   pop_job,
   output sbl_qstat_type qstat
);

   sbl_job_type            entry_ff [0:QUEUE_DEPTH-1];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_BITS:0]     count_ff, count_in;
   logic                   do_push, do_pop;

   assign qstat.room      = (count_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign qstat.not_empty = (count_ff != '0);

   assign do_push = push && qstat.room;
   assign do_pop  = pop && qstat.not_empty;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Track fill level and pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign pop_job = entry_ff[rd_ptr_ff];

endmodule

// ===== design/sbl_back.sv =====
// Magnitude pipeline: squares, then one square root digit per stage.
module sbl_back import sbl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  sbl_qstat_type       qstat,
   input  sbl_job_type         pop_job,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [MAG_BITS-1:0] rsp_magnitude,
   output logic [COL_BITS-1:0] rsp_centre_column,
   output logic [ROW_BITS-1:0] rsp_centre_row,
   output logic                rsp_frame_end
);

   localparam int STAGES   = MAG_BITS + 1;
   localparam int REM_BITS = MAG_BITS + 3;

   typedef struct packed {
      logic [REM_BITS-1:0] rem;
      logic [MAG_BITS-1:0] root;
   } sqrt_state_type;

   logic                    valid_ff [0:STAGES-1];
   logic [SUMSQ_BITS-1:0]   value_ff [0:STAGES-1];
   logic [REM_BITS-1:0]     rem_ff   [0:STAGES-1];
   logic [MAG_BITS-1:0]     root_ff  [0:STAGES-1];
   logic [COL_BITS-1:0]     col_ff   [0:STAGES-1];
   logic [ROW_BITS-1:0]     row_ff   [0:STAGES-1];
   logic                    fend_ff  [0:STAGES-1];

   logic                          enable;
   logic signed [SUMSQ_BITS-1:0]  gx_sq, gy_sq;
   logic [SUMSQ_BITS-1:0]         sumsq;
   sqrt_state_type                step_out [1:STAGES-1];

   // One restoring square root step on the next two bits of the operand
   function automatic sqrt_state_type sqrt_step(
      input logic [REM_BITS-1:0] rem,
      input logic [MAG_BITS-1:0] root,
      input logic [1:0]          pair
   );
      logic [REM_BITS-1:0] shifted;
      logic [REM_BITS-1:0] trial;
      sqrt_state_type      res;
      shifted = {rem[REM_BITS-3:0], pair};
      trial   = {1'b0, root, 2'b01};
      if (shifted >= trial) begin
         res.rem  = shifted - trial;
         res.root = {root[MAG_BITS-2:0], 1'b1};
      end else begin
         res.rem  = shifted;
         res.root = {root[MAG_BITS-2:0], 1'b0};
      end
      return res;
   endfunction

   // Whole pipeline moves unless the result register is held
   assign enable = !(valid_ff[STAGES-1] && rsp_stall);
   assign pop    = enable && qstat.not_empty;

   assign gx_sq = pop_job.gx * pop_job.gx;
   assign gy_sq = pop_job.gy * pop_job.gy;
   assign sumsq = $unsigned(gx_sq) + $unsigned(gy_sq);

   for (genvar s = 1; s < STAGES; s++) begin : g_step
      assign step_out[s] = sqrt_step(rem_ff[s-1], root_ff[s-1],
                                     value_ff[s-1][2*(STAGES-1-s)+1 -: 2]);
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (enable) begin
         valid_ff[0] <= qstat.not_empty;
         for (int s = 1; s < STAGES; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (enable) begin
         value_ff[0] <= sumsq;
         rem_ff[0]   <= '0;
         root_ff[0]  <= '0;
         col_ff[0]   <= pop_job.col;
         row_ff[0]   <= pop_job.row;
         fend_ff[0]  <= pop_job.frame_end;
         for (int s = 1; s < STAGES; s++) begin
            value_ff[s] <= value_ff[s-1];
            rem_ff[s]   <= step_out[s].rem;
            root_ff[s]  <= step_out[s].root;
            col_ff[s]   <= col_ff[s-1];
            row_ff[s]   <= row_ff[s-1];
            fend_ff[s]  <= fend_ff[s-1];
         end
      end
   end

   assign rsp_valid         = valid_ff[STAGES-1];
   assign rsp_magnitude     = root_ff[STAGES-1];
   assign rsp_centre_column = col_ff[STAGES-1];
   assign rsp_centre_row    = row_ff[STAGES-1];
   assign rsp_frame_end     = fend_ff[STAGES-1];

endmodule

// ===== design/sobel_edge_magnitude_unit.sv =====
// Top level of the streaming 3x3 Sobel gradient magnitude unit.
//
//   channel   direction  handshake           payload
//   req       in         req_valid/stall     pixel, frame_start
//   rsp       out        rsp_valid/stall     magnitude, centre_column, centre_row, frame_end
//   csr       in/out     psel/penable/pready image_width @0x0, image_height @0x4
//
// One pixel per clock unless stalled; line stores use one read and one write port per cycle.
// A result passes one front stage, a queue slot and twelve back stages.
// Reset is synchronous and clears counters, window taps, queue and valids; line stores are not
// cleared and need no clearing pass. A held result freezes the back pipeline, the queue then
// fills and the front stalls the pixel input only when its job finds no room.
module sobel_edge_magnitude_unit import sbl_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [PIXEL_BITS-1:0]    req_pixel,
   input  logic                     req_frame_start,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [MAG_BITS-1:0]      rsp_magnitude,
   output logic [COL_BITS-1:0]      rsp_centre_column,
   output logic [ROW_BITS-1:0]      rsp_centre_row,
   output logic                     rsp_frame_end,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic [WIDTH_BITS-1:0]  width_ff;
   logic [HEIGHT_BITS-1:0] height_ff;
   logic [WIDTH_BITS-1:0]  width_eff;
   logic [HEIGHT_BITS-1:0] height_eff;
   logic                   csr_write;
   sbl_limits_type         limits;
   sbl_qstat_type          qstat;
   logic                   push, pop;
   sbl_job_type            push_job, pop_job;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_IMAGE_WIDTH:  width_ff  <= pwdata[WIDTH_BITS-1:0];
            REG_IMAGE_HEIGHT: height_ff <= pwdata[HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (paddr[2])
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_BITS'(width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_BITS'(height_ff);
         default:          prdata = '0;
      endcase
   end

   // Clamp the frame size into the supported range
   always_comb begin
      if (width_ff < WIDTH_MIN) begin
         width_eff = WIDTH_MIN;
      end else if (width_ff > WIDTH_MAX) begin
         width_eff = WIDTH_MAX;
      end else begin
         width_eff = width_ff;
      end
      if (height_ff < HEIGHT_MIN) begin
         height_eff = HEIGHT_MIN;
      end else if (height_ff > HEIGHT_MAX) begin
         height_eff = HEIGHT_MAX;
      end else begin
         height_eff = height_ff;
      end
   end

   assign limits.col_last = COL_BITS'(width_eff - 1'b1);
   assign limits.row_last = ROW_BITS'(height_eff - 1'b1);

   sbl_front u_front (
      .clock           (clock),
      .reset           (reset),
      .limits          (limits),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .qstat           (qstat),
      .push            (push),
      .push_job        (push_job)
   );

   sbl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .qstat    (qstat)
   );

   sbl_back u_back (
      .clock             (clock),
      .reset             (reset),
      .qstat             (qstat),
      .pop_job           (pop_job),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_magnitude     (rsp_magnitude),
      .rsp_centre_column (rsp_centre_column),
      .rsp_centre_row    (rsp_centre_row),
      .rsp_frame_end     (rsp_frame_end)
   );

endmodule

// ===== bench/sobel_magnitude_checker.sv =====
// Checker for the Sobel edge magnitude unit: tracks registers, predicts results, compares them.
module sobel_magnitude_checker import sbl_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [PIXEL_BITS-1:0]    req_pixel,
   input  logic                     req_frame_start,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [MAG_BITS-1:0]      rsp_magnitude,
   input  logic [COL_BITS-1:0]      rsp_centre_column,
   input  logic [ROW_BITS-1:0]      rsp_centre_row,
   input  logic                     rsp_frame_end,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   input  logic [CSR_DATA_BITS-1:0] prdata,
   input  logic                     pready,
   output int                       fail_count,
   output int                       pending_count
);

   localparam logic [CSR_ADDR_BITS-1:0] WIDTH_ADDR  = CSR_ADDR_BITS'(4 * REG_IMAGE_WIDTH);
   localparam logic [CSR_ADDR_BITS-1:0] HEIGHT_ADDR = CSR_ADDR_BITS'(4 * REG_IMAGE_HEIGHT);

   typedef struct packed {
      logic [MAG_BITS-1:0] magnitude;
      logic [COL_BITS-1:0] column;
      logic [ROW_BITS-1:0] row;
      logic                frame_end;
   } edge_result_type;

   // Register copies and the streaming window state
   logic [WIDTH_BITS-1:0]  width_reg;
   logic [HEIGHT_BITS-1:0] height_reg;
   bit   [PIXEL_BITS-1:0]  upper_row [MAX_WIDTH];
   bit   [PIXEL_BITS-1:0]  middle_row [MAX_WIDTH];
   bit   [PIXEL_BITS-1:0]  window [6];
   int                     col_cnt;
   int                     row_cnt;
   edge_result_type        awaited_magnitudes [$];

   // Floor of the square root, one result bit at a time from the top
   function automatic int floor_sqrt(input int value);
      int root;
      int trial;
      root = 0;
      for (int b = MAG_BITS - 1; b >= 0; b--) begin
         trial = root | (1 << b);
         if (trial * trial <= value) root = trial;
      end
      return root;
   endfunction

   function automatic int clamp_size(input int value, input int upper);
      if (value < 3) return 3;
      if (value > upper) return upper;
      return value;
   endfunction

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         fail_count++;
      end
   endtask

   // Shift one pixel through the window and queue the magnitude it completes
   task automatic correlate_pixel(input logic [PIXEL_BITS-1:0] pix, input logic restart);
      int w, h, c, r, ci, gx, gy;
      int up, mid, p;
      edge_result_type res;
      w = clamp_size(int'(width_reg), MAX_WIDTH);
      h = clamp_size(int'(height_reg), MAX_HEIGHT);
      if (restart) begin
         col_cnt = 0;
         row_cnt = 0;
      end
      c  = col_cnt;
      r  = row_cnt;
      ci = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
      up  = int'(upper_row[ci]);
      mid = int'(middle_row[ci]);
      p   = int'(pix);
      if (c >= 2 && r >= 2) begin
         gx = (int'(window[0]) + 2 * int'(window[1]) + int'(window[2])) - (up + 2 * mid + p);
         gy = (int'(window[0]) + 2 * int'(window[3]) + up)
              - (int'(window[2]) + 2 * int'(window[5]) + p);
         res.magnitude = MAG_BITS'(floor_sqrt(gx * gx + gy * gy));
         res.column    = COL_BITS'(c - 1);
         res.row       = ROW_BITS'(r - 1);
         res.frame_end = (c == w - 1) && (r == h - 1);
         awaited_magnitudes.push_back(res);
      end
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = PIXEL_BITS'(up);
      window[4] = PIXEL_BITS'(mid);
      window[5] = pix;
      upper_row[ci]  = PIXEL_BITS'(mid);
      middle_row[ci] = pix;
      // advance column, wrap row at the end of the line and of the frame
      if (c >= w - 1) begin
         col_cnt = 0;
         row_cnt = (r >= h - 1) ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
      end
   endtask

   always @(posedge clock) begin : monitor
      edge_result_type want;
      if (reset) begin
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         col_cnt    = 0;
         row_cnt    = 0;
         fail_count = 0;
         for (int i = 0; i < 6; i++) window[i] = '0;
         awaited_magnitudes.delete();
      end else begin
         // compare a result transfer with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (awaited_magnitudes.size() == 0) begin
               $display("%0t: unexpected result, magnitude %0d column %0d row %0d", $time,
                        rsp_magnitude, rsp_centre_column, rsp_centre_row);
               fail_count++;
            end else begin
               want = awaited_magnitudes.pop_front();
               check_field("magnitude", want.magnitude, rsp_magnitude);
               check_field("centre_column", want.column, rsp_centre_column);
               check_field("centre_row", want.row, rsp_centre_row);
               check_field("frame_end", want.frame_end, rsp_frame_end);
            end
         end
         if (req_valid && !req_stall) correlate_pixel(req_pixel, req_frame_start);
         // track register writes, check reads
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr == WIDTH_ADDR) width_reg = pwdata[WIDTH_BITS-1:0];
               else if (paddr == HEIGHT_ADDR) height_reg = pwdata[HEIGHT_BITS-1:0];
            end else if (paddr == WIDTH_ADDR) begin
               check_field("image_width read", 32'(width_reg), prdata);
            end else if (paddr == HEIGHT_ADDR) begin
               check_field("image_height read", 32'(height_reg), prdata);
            end
         end
      end
      pending_count <= awaited_magnitudes.size();
   end

endmodule

// ===== bench/sobel_edge_magnitude_unit_tb.sv =====
// Testbench top for the Sobel edge magnitude unit: stimulus, register setup and verdict.
module sobel_edge_magnitude_unit_tb;
   import sbl_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 24;
   localparam logic [CSR_ADDR_BITS-1:0] WIDTH_ADDR  = CSR_ADDR_BITS'(4 * REG_IMAGE_WIDTH);
   localparam logic [CSR_ADDR_BITS-1:0] HEIGHT_ADDR = CSR_ADDR_BITS'(4 * REG_IMAGE_HEIGHT);

   // Window with a strong corner: left column and top middle bright
   localparam logic [PIXEL_BITS-1:0] CORNER [9] = '{8'd255, 8'd255, 8'd0,
                                                    8'd255, 8'd0,   8'd0,
                                                    8'd255, 8'd0,   8'd0};

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [PIXEL_BITS-1:0]    req_pixel;
   logic                     req_frame_start;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [MAG_BITS-1:0]      rsp_magnitude;
   logic [COL_BITS-1:0]      rsp_centre_column;
   logic [ROW_BITS-1:0]      rsp_centre_row;
   logic                     rsp_frame_end;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;
   int                       fail_count;
   int                       pending_count;

   // Stimulus bookkeeping: register copies, column position, per-column fill count
   logic [WIDTH_BITS-1:0]  width_val;
   logic [HEIGHT_BITS-1:0] height_val;
   int                     eff_width;
   int                     eff_height;
   int                     col_pos;
   byte unsigned           col_visits [MAX_WIDTH];
   bit                     no_gaps;
   bit                     need_restart;
   int                     idle_cycles;

   sobel_edge_magnitude_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel         (req_pixel),
      .req_frame_start   (req_frame_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_magnitude     (rsp_magnitude),
      .rsp_centre_column (rsp_centre_column),
      .rsp_centre_row    (rsp_centre_row),
      .rsp_frame_end     (rsp_frame_end),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   sobel_magnitude_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel         (req_pixel),
      .req_frame_start   (req_frame_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_magnitude     (rsp_magnitude),
      .rsp_centre_column (rsp_centre_column),
      .rsp_centre_row    (rsp_centre_row),
      .rsp_frame_end     (rsp_frame_end),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Stall the result side in bursts: mostly short, some long, some clean stretches
   initial begin : stall_driver
      int run;
      bit held;
      forever begin
         case (1'b1)
            ($urandom_range(0, 99) < 45): begin held = 1'b0; run = $urandom_range(1, 8); end
            ($urandom_range(0, 99) < 30): begin held = 1'b0; run = $urandom_range(50, 200); end
            ($urandom_range(0, 99) < 85): begin held = 1'b1; run = $urandom_range(1, 3); end
            default:                      begin held = 1'b1; run = $urandom_range(15, 60); end
         endcase
         repeat (run) begin
            rsp_stall <= held;
            @(posedge clock);
         end
      end
   end

   // End the run when nothing has been transferred for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offer one pixel and hold it until transfer
   task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix, input logic restart);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel       <= pix;
      req_frame_start <= restart;
      do @(posedge clock); while (req_stall);
      if (restart) col_pos = 0;
      if (col_visits[col_pos] < 2) col_visits[col_pos]++;
      col_pos = (col_pos >= eff_width - 1) ? 0 : col_pos + 1;
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_BITS-1:0] addr,
                             input logic [CSR_DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Drain the block, write the size registers, read them back
   task automatic set_size(input logic [WIDTH_BITS-1:0] w_val, input logic [HEIGHT_BITS-1:0] h_val,
                           input bit write_w, input bit write_h);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (write_w) begin
         csr_access(1'b1, WIDTH_ADDR, ($urandom & ~32'h7FF) | 32'(w_val));
         width_val = w_val;
      end
      if (write_h) begin
         csr_access(1'b1, HEIGHT_ADDR, ($urandom & ~32'h7FF) | 32'(h_val));
         height_val = h_val;
      end
      csr_access(1'b0, WIDTH_ADDR, '0);
      csr_access(1'b0, HEIGHT_ADDR, '0);
      eff_width  = (width_val < 3) ? 3 : ((width_val > MAX_WIDTH) ? MAX_WIDTH : int'(width_val));
      eff_height = (height_val < 3) ? 3 : ((height_val > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_val));
      // a column never filled twice must not be read: restart the frame then
      need_restart = 1'b0;
      for (int i = 0; i < eff_width; i++) if (col_visits[i] < 2) need_restart = 1'b1;
   endtask

   initial begin : stimulus
      int phase;
      int small_sent;
      int frames;
      int len;
      int extra;
      bit binary;
      bit restart_first;
      logic [WIDTH_BITS-1:0]  w_pick;
      logic [HEIGHT_BITS-1:0] h_pick;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_pixel       <= '0;
      req_frame_start <= 1'b0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      width_val  = WIDTH_RESET;
      height_val = HEIGHT_RESET;
      eff_width  = int'(WIDTH_RESET);
      eff_height = int'(HEIGHT_RESET);
      col_pos    = 0;
      no_gaps    = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Undersized registers act as a 3x3 frame
      set_size(WIDTH_BITS'(2), HEIGHT_BITS'(1), 1'b1, 1'b1);
      for (int i = 0; i < 9; i++) send_pixel(CORNER[i], i == 0);
      // next frame without frame_start, inverted for negative gradients
      for (int i = 0; i < 9; i++) send_pixel(~CORNER[i], 1'b0);
      // restart in the middle of a row
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'h5A, 1'b1);

      phase      = 0;
      small_sent = 0;
      while (small_sent < RANDOM_ITEMS) begin
         no_gaps = ($urandom_range(0, 4) == 0);
         if (phase == 2) begin
            // widest rows: fill two full rows and part of the third
            w_pick = $urandom_range(0, 1) ? WIDTH_MAX : WIDTH_BITS'($urandom_range(1025, 2047));
            h_pick = HEIGHT_BITS'($urandom_range(3, 6));
            set_size(w_pick, h_pick, 1'b1, 1'b1);
            extra = 2 * MAX_WIDTH + $urandom_range(8, 64);
            for (int k = 0; k < extra; k++) send_pixel(PIXEL_BITS'($urandom), k == 0);
         end else if (phase == 5) begin
            // tallest frame on the narrowest rows, left unfinished
            w_pick = WIDTH_BITS'($urandom_range(0, 3));
            h_pick = $urandom_range(0, 1) ? HEIGHT_MAX : HEIGHT_BITS'($urandom_range(1025, 2047));
            set_size(w_pick, h_pick, 1'b1, 1'b1);
            extra = $urandom_range(200, 400);
            for (int k = 0; k < extra; k++)
               send_pixel(PIXEL_BITS'($urandom), (k == 0) && (need_restart || $urandom_range(0, 1)));
         end else begin
            w_pick = ($urandom_range(0, 9) == 0) ? WIDTH_BITS'($urandom_range(0, 2))
                                                 : WIDTH_BITS'($urandom_range(3, 16));
            h_pick = ($urandom_range(0, 9) == 0) ? HEIGHT_BITS'($urandom_range(0, 2))
                                                 : HEIGHT_BITS'($urandom_range(3, 10));
            set_size(w_pick, h_pick, $urandom_range(0, 9) < 7, $urandom_range(0, 9) < 7);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
               len = eff_width * eff_height;
               if ($urandom_range(0, 99) < 15) len = $urandom_range(1, len);
               binary        = ($urandom_range(0, 4) == 0);
               restart_first = ((f == 0) && need_restart) || ($urandom_range(0, 99) < 80);
               // whole or partial frames with random content, a few stray restarts
               for (int k = 0; k < len; k++)
                  send_pixel(binary ? ($urandom_range(0, 1) ? 8'd255 : 8'd0) : PIXEL_BITS'($urandom),
                             ((k == 0) && restart_first) || ($urandom_range(0, 199) == 0));
               small_sent += len;
            end
         end
         phase++;
      end

      // Drop valid, drain, let the pipeline settle
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
